@@ hw/rtl/stramp_pkg.sv @@
// ----------------------------------------------------------------------------
// stramp_pkg: shared types and constants of the trapezoidal step-rate ramp
// Action codes, register indexes, drive states and fixed field widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stramp_pkg;

    localparam int ACTION_WIDTH    = 3;
    localparam int STATUS_WIDTH    = 2;
    localparam int CURRENT_WIDTH   = 12;
    localparam int CFG_INDEX_WIDTH = 3;

    // Reset values of the configuration registers
    localparam int SLOW_PERIOD_RST  = 2000;
    localparam int FAST_PERIOD_RST  = 200;
    localparam int RAMP_STEP_RST    = 10;
    localparam logic [CURRENT_WIDTH-1:0] RUN_CURRENT_RST  = 12'd1000;
    localparam logic [CURRENT_WIDTH-1:0] STOP_CURRENT_RST = 12'd200;

    typedef enum logic [ACTION_WIDTH-1:0] {
        ACT_MOVE  = 3'd0,
        ACT_RUN   = 3'd1,
        ACT_TICK  = 3'd2,
        ACT_PULSE = 3'd3,
        ACT_BRAKE = 3'd4
    } action_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_SLOW_PERIOD  = 3'd0,
        REG_FAST_PERIOD  = 3'd1,
        REG_RAMP_STEP    = 3'd2,
        REG_RUN_CURRENT  = 3'd3,
        REG_STOP_CURRENT = 3'd4
    } cfg_reg_t;

    // Drive state, one-hot
    typedef enum logic [3:0] {
        DRV_STOPPED = 4'b0001,
        DRV_ACCEL   = 4'b0010,
        DRV_CRUISE  = 4'b0100,
        DRV_BRAKE   = 4'b1000
    } drive_state_t;

    // Reported status codes
    localparam logic [STATUS_WIDTH-1:0] STATUS_STOPPED = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] STATUS_ACCEL   = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] STATUS_CRUISE  = 2'd2;
    localparam logic [STATUS_WIDTH-1:0] STATUS_BRAKE   = 2'd3;

    function automatic logic [STATUS_WIDTH-1:0] encode_status(input drive_state_t st);
        logic [STATUS_WIDTH-1:0] code;
        unique case (st)
            DRV_STOPPED: code = STATUS_STOPPED;
            DRV_ACCEL:   code = STATUS_ACCEL;
            DRV_CRUISE:  code = STATUS_CRUISE;
            DRV_BRAKE:   code = STATUS_BRAKE;
            default:     code = STATUS_STOPPED;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/stramp_if.sv @@
// ----------------------------------------------------------------------------
// stramp_if: item channels of the step-rate ramp
// Command channel (action and move arguments) and result channel (drive view).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface stramp_in_if #(
    parameter int COUNT_WIDTH = 24
) ();
    logic                                 valid;
    logic                                 ready;
    logic [stramp_pkg::ACTION_WIDTH-1:0]  action;
    logic [COUNT_WIDTH-1:0]               step_count;
    logic                                 move_dir;

    modport source (output valid, output action, output step_count, output move_dir,
                    input ready);
    modport sink   (input valid, input action, input step_count, input move_dir,
                    output ready);
endinterface

interface stramp_out_if #(
    parameter int PERIOD_WIDTH = 16
) ();
    logic                                  valid;
    logic                                  ready;
    logic [PERIOD_WIDTH-1:0]               step_period;
    logic [stramp_pkg::STATUS_WIDTH-1:0]   motor_status;
    logic                                  dir_out;
    logic [stramp_pkg::CURRENT_WIDTH-1:0]  current_setpoint;
    logic                                  pulses_on;
    logic                                  ramp_ticks_on;

    modport source (output valid, output step_period, output motor_status, output dir_out,
                    output current_setpoint, output pulses_on, output ramp_ticks_on,
                    input ready);
    modport sink   (input valid, input step_period, input motor_status, input dir_out,
                    input current_setpoint, input pulses_on, input ramp_ticks_on,
                    output ready);
endinterface

`default_nettype wire

@@ hw/rtl/stramp_core.sv @@
// ----------------------------------------------------------------------------
// stramp_core: ramp state and its combinational update
// Holds the drive state and applies one action per enabled cycle; the
// updated state is also presented so the caller can register it as a result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stramp_core #(
    parameter int COUNT_WIDTH  = 24,
    parameter int PERIOD_WIDTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 en,
    input  wire stramp_pkg::action_t                  action,
    input  wire logic [COUNT_WIDTH-1:0]               step_count,
    input  wire logic                                 move_dir,
    input  wire logic [PERIOD_WIDTH-1:0]              slow_period,
    input  wire logic [PERIOD_WIDTH-1:0]              fast_period,
    input  wire logic [PERIOD_WIDTH-1:0]              ramp_step,
    input  wire logic [stramp_pkg::CURRENT_WIDTH-1:0] run_current,
    input  wire logic [stramp_pkg::CURRENT_WIDTH-1:0] stop_current,
    output logic [PERIOD_WIDTH-1:0]                   period_next,
    output logic [stramp_pkg::STATUS_WIDTH-1:0]       status_code_next,
    output logic                                      dir_next,
    output logic [stramp_pkg::CURRENT_WIDTH-1:0]      current_next,
    output logic                                      pulse_run_next,
    output logic                                      tick_run_next
);
    import stramp_pkg::*;

    drive_state_t              status_reg, status_next;
    logic [PERIOD_WIDTH-1:0]   period_reg;
    logic [COUNT_WIDTH-1:0]    total_reg, total_next;
    logic [COUNT_WIDTH-1:0]    passed_reg, passed_next;
    logic [COUNT_WIDTH-1:0]    accel_reg, accel_next;
    logic [COUNT_WIDTH-1:0]    count_reg, count_next;
    logic [COUNT_WIDTH-1:0]    limit_reg, limit_next;
    logic                      free_reg, free_next;
    logic                      dir_reg;
    logic [CURRENT_WIDTH-1:0]  current_reg;
    logic                      pulse_run_reg;
    logic                      tick_run_reg;

    logic                      start_drive;
    logic                      halt_drive;
    logic [PERIOD_WIDTH:0]     fast_plus_step;
    logic [PERIOD_WIDTH:0]     period_plus_step;
    logic [COUNT_WIDTH:0]      total_plus_one;
    logic [COUNT_WIDTH+1:0]    brake_margin;
    logic [COUNT_WIDTH-1:0]    passed_at_cruise;
    logic [COUNT_WIDTH-1:0]    passed_at_limit;
    logic [CURRENT_WIDTH-1:0]  drive_current;

    // Ramp arithmetic, one adder or compare deep each
    assign fast_plus_step   = {1'b0, fast_period} + {1'b0, ramp_step};
    assign period_plus_step = {1'b0, period_reg} + {1'b0, ramp_step};
    assign total_plus_one   = {1'b0, total_reg} + {{COUNT_WIDTH{1'b0}}, 1'b1};
    assign brake_margin     = ({2'b00, count_reg} + (COUNT_WIDTH+2)'(2)) << 1;
    assign passed_at_cruise = passed_reg + count_reg;
    assign passed_at_limit  = passed_reg + limit_reg;
    assign drive_current    = (run_current < stop_current) ? stop_current : run_current;

    always_comb
    begin
        status_next    = status_reg;
        period_next    = period_reg;
        total_next     = total_reg;
        passed_next    = passed_reg;
        accel_next     = accel_reg;
        count_next     = count_reg;
        limit_next     = limit_reg;
        free_next      = free_reg;
        dir_next       = dir_reg;
        current_next   = current_reg;
        pulse_run_next = pulse_run_reg;
        tick_run_next  = tick_run_reg;
        start_drive    = 1'b0;
        halt_drive     = 1'b0;

        case (action)
            ACT_MOVE:
            begin
                total_next  = step_count - COUNT_WIDTH'(1);
                limit_next  = step_count - COUNT_WIDTH'(1);
                passed_next = '0;
                count_next  = '0;
                dir_next    = move_dir;
                free_next   = 1'b0;
                start_drive = 1'b1;
            end
            ACT_RUN:
            begin
                free_next   = 1'b1;
                start_drive = 1'b1;
            end
            ACT_TICK:
            begin
                if (tick_run_reg && status_reg == DRV_ACCEL)
                begin
                    if ({1'b0, period_reg} <= fast_plus_step)
                    begin
                        accel_next    = count_reg;
                        passed_next   = passed_at_cruise;
                        period_next   = fast_period;
                        status_next   = DRV_CRUISE;
                        tick_run_next = 1'b0;
                        // braking point: total + 1 - 2 * (accel + 2), floored at zero
                        if ({1'b0, total_plus_one} > brake_margin)
                            limit_next = COUNT_WIDTH'({1'b0, total_plus_one} - brake_margin);
                        else
                            limit_next = '0;
                    end
                    else
                    begin
                        period_next = period_reg - ramp_step;
                    end
                end
                else if (tick_run_reg && status_reg == DRV_BRAKE)
                begin
                    if (period_plus_step >= {1'b0, slow_period})
                    begin
                        period_next = slow_period;
                        if (free_reg)
                            halt_drive = 1'b1;
                        else
                            tick_run_next = 1'b0;
                    end
                    else
                    begin
                        period_next = period_plus_step[PERIOD_WIDTH-1:0];
                    end
                end
            end
            ACT_PULSE:
            begin
                if (pulse_run_reg)
                begin
                    if (count_reg >= limit_reg)
                    begin
                        count_next = '0;
                        if (!free_reg && status_reg == DRV_CRUISE)
                        begin
                            passed_next   = passed_at_limit;
                            limit_next    = (total_reg > passed_at_limit)
                                          ? (total_reg - passed_at_limit) : '0;
                            status_next   = DRV_BRAKE;
                            tick_run_next = 1'b1;
                        end
                        else if (!free_reg && status_reg == DRV_BRAKE)
                        begin
                            halt_drive = 1'b1;
                        end
                    end
                    else
                    begin
                        count_next = count_reg + COUNT_WIDTH'(1);
                    end
                end
            end
            ACT_BRAKE:
            begin
                if (status_reg != DRV_STOPPED)
                begin
                    status_next   = DRV_BRAKE;
                    tick_run_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (start_drive)
        begin
            period_next    = slow_period;
            current_next   = drive_current;
            status_next    = DRV_ACCEL;
            pulse_run_next = 1'b1;
            tick_run_next  = 1'b1;
        end

        if (halt_drive)
        begin
            pulse_run_next = 1'b0;
            tick_run_next  = 1'b0;
            current_next   = stop_current;
            status_next    = DRV_STOPPED;
            count_next     = '0;
            total_next     = '0;
            passed_next    = '0;
            accel_next     = '0;
        end
    end

    assign status_code_next = encode_status(status_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg    <= DRV_STOPPED;
            period_reg    <= PERIOD_WIDTH'(SLOW_PERIOD_RST);
            total_reg     <= '0;
            passed_reg    <= '0;
            accel_reg     <= '0;
            count_reg     <= '0;
            limit_reg     <= '0;
            free_reg      <= 1'b0;
            dir_reg       <= 1'b0;
            current_reg   <= STOP_CURRENT_RST;
            pulse_run_reg <= 1'b0;
            tick_run_reg  <= 1'b0;
        end
        else if (en)
        begin
            status_reg    <= status_next;
            period_reg    <= period_next;
            total_reg     <= total_next;
            passed_reg    <= passed_next;
            accel_reg     <= accel_next;
            count_reg     <= count_next;
            limit_reg     <= limit_next;
            free_reg      <= free_next;
            dir_reg       <= dir_next;
            current_reg   <= current_next;
            pulse_run_reg <= pulse_run_next;
            tick_run_reg  <= tick_run_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/stepper_trapezoid_ramp_top.sv @@
// ----------------------------------------------------------------------------
// stepper_trapezoid_ramp_top: trapezoidal step-rate ramp generator
// Turns move, run, ramp-tick, step-pulse and brake items into the drive's
// step period, status, direction, current setpoint and timer enables.
// ----------------------------------------------------------------------------
// Usage:
//   cmd  - command items (action, step_count, move_dir), valid/ready.
//   rsp  - one result item per command: the drive state after that command.
//   cfg_we/cfg_index/cfg_data - register writes (slow/fast period, ramp step,
//          run and stop current); write only while no item is in flight.
// An accepted item sits in the input register; when it advances, the ramp
// update loads the result register, which presents it on rsp. One item per
// cycle is sustained while rsp is not stalled; each update is a single pass
// of adders and comparators on the held state, so consecutive items chain
// through the state registers without a bubble.
// Reset clears both item stages, stops the drive with the period at the
// slow value and the current at the stop level, and restores the register
// defaults. When the receiver stalls the result register holds, the input
// register takes one more item and then cmd.ready drops until rsp drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stepper_trapezoid_ramp_top #(
    parameter int COUNT_WIDTH  = 24,
    parameter int PERIOD_WIDTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    stramp_in_if.sink                                   cmd,
    stramp_out_if.source                                rsp,
    input  wire logic                                   cfg_we,
    input  wire logic [stramp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [((PERIOD_WIDTH > stramp_pkg::CURRENT_WIDTH)
                        ? PERIOD_WIDTH : stramp_pkg::CURRENT_WIDTH)-1:0] cfg_data
);
    import stramp_pkg::*;

    // Configuration registers
    logic [PERIOD_WIDTH-1:0]   slow_period_reg;
    logic [PERIOD_WIDTH-1:0]   fast_period_reg;
    logic [PERIOD_WIDTH-1:0]   ramp_step_reg;
    logic [CURRENT_WIDTH-1:0]  run_current_reg;
    logic [CURRENT_WIDTH-1:0]  stop_current_reg;

    // Input stage
    logic                      in_valid_reg;
    logic [ACTION_WIDTH-1:0]   action_reg;
    logic [COUNT_WIDTH-1:0]    step_count_reg;
    logic                      move_dir_reg;

    // Result stage
    logic                      out_valid_reg;
    logic [PERIOD_WIDTH-1:0]   step_period_reg;
    logic [STATUS_WIDTH-1:0]   motor_status_reg;
    logic                      dir_out_reg;
    logic [CURRENT_WIDTH-1:0]  current_setpoint_reg;
    logic                      pulses_on_reg;
    logic                      ramp_ticks_on_reg;

    // Updated drive view from the core
    logic [PERIOD_WIDTH-1:0]   period_next;
    logic [STATUS_WIDTH-1:0]   status_code_next;
    logic                      dir_next;
    logic [CURRENT_WIDTH-1:0]  current_next;
    logic                      pulse_run_next;
    logic                      tick_run_next;

    logic                      advance;
    logic                      take_cmd;

    // Advance the held item when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !in_valid_reg || advance;
    assign take_cmd = cmd.valid && cmd.ready;

    // Register writes; an unknown index is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_period_reg  <= PERIOD_WIDTH'(SLOW_PERIOD_RST);
            fast_period_reg  <= PERIOD_WIDTH'(FAST_PERIOD_RST);
            ramp_step_reg    <= PERIOD_WIDTH'(RAMP_STEP_RST);
            run_current_reg  <= RUN_CURRENT_RST;
            stop_current_reg <= STOP_CURRENT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SLOW_PERIOD:  slow_period_reg  <= cfg_data[PERIOD_WIDTH-1:0];
                REG_FAST_PERIOD:  fast_period_reg  <= cfg_data[PERIOD_WIDTH-1:0];
                REG_RAMP_STEP:    ramp_step_reg    <= cfg_data[PERIOD_WIDTH-1:0];
                REG_RUN_CURRENT:  run_current_reg  <= cfg_data[CURRENT_WIDTH-1:0];
                REG_STOP_CURRENT: stop_current_reg <= cfg_data[CURRENT_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Input register: hold the item until the core takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (take_cmd)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take_cmd)
        begin
            action_reg     <= cmd.action;
            step_count_reg <= cmd.step_count;
            move_dir_reg   <= cmd.move_dir;
        end
    end

    stramp_core #(
        .COUNT_WIDTH  (COUNT_WIDTH),
        .PERIOD_WIDTH (PERIOD_WIDTH)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (advance),
        .action           (action_t'(action_reg)),
        .step_count       (step_count_reg),
        .move_dir         (move_dir_reg),
        .slow_period      (slow_period_reg),
        .fast_period      (fast_period_reg),
        .ramp_step        (ramp_step_reg),
        .run_current      (run_current_reg),
        .stop_current     (stop_current_reg),
        .period_next      (period_next),
        .status_code_next (status_code_next),
        .dir_next         (dir_next),
        .current_next     (current_next),
        .pulse_run_next   (pulse_run_next),
        .tick_run_next    (tick_run_next)
    );

    // Result register: capture the updated view, hold it while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            step_period_reg      <= period_next;
            motor_status_reg     <= status_code_next;
            dir_out_reg          <= dir_next;
            current_setpoint_reg <= current_next;
            pulses_on_reg        <= pulse_run_next;
            ramp_ticks_on_reg    <= tick_run_next;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.step_period      = step_period_reg;
    assign rsp.motor_status     = motor_status_reg;
    assign rsp.dir_out          = dir_out_reg;
    assign rsp.current_setpoint = current_setpoint_reg;
    assign rsp.pulses_on        = pulses_on_reg;
    assign rsp.ramp_ticks_on    = ramp_ticks_on_reg;

endmodule

`default_nettype wire

@@ dv/stepper_trapezoid_ramp_top_test.sv @@
// ----------------------------------------------------------------------------
// stepper_trapezoid_ramp_top_test: self-checking bench for the step-rate ramp
// Drives move, run, ramp-tick, step-pulse and brake items into the command
// channel under several register settings and handshake pressures. Tracks
// the drive state in a local model and checks every result item field by
// field against it, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stepper_trapezoid_ramp_top_test;

    import stramp_pkg::*;

    localparam int COUNT_W      = 24;
    localparam int PERIOD_W     = 16;
    localparam int CFG_DATA_W   = (PERIOD_W > CURRENT_WIDTH) ? PERIOD_W : CURRENT_WIDTH;
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int RANDOM_ITEMS = 142;    // per random phase, eight phases
    localparam int DRAIN_CYCLES = 8;      // idle clocks after the last result

    // Action codes past the end of the list; the block must leave its state alone
    localparam logic [ACTION_WIDTH-1:0] ACT_SPARE_FIRST = ACT_BRAKE + 1;
    localparam logic [ACTION_WIDTH-1:0] ACT_SPARE_LAST  = '1;

    typedef struct {
        logic [ACTION_WIDTH-1:0] action;
        logic [COUNT_W-1:0]      count;
        logic                    dir;
    } ramp_cmd_t;

    typedef struct packed {
        logic [PERIOD_W-1:0]      period;
        logic [STATUS_WIDTH-1:0]  status;
        logic                     dir;
        logic [CURRENT_WIDTH-1:0] current;
        logic                     pulses_on;
        logic                     ticks_on;
    } drive_view_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the channels
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    stramp_in_if  #(.COUNT_WIDTH(COUNT_W))   cmd_ch ();
    stramp_out_if #(.PERIOD_WIDTH(PERIOD_W)) rsp_ch ();

    // Everything the bench drives starts at a known value
    logic                       cmd_valid  = 1'b0;
    logic [ACTION_WIDTH-1:0]    cmd_action = '0;
    logic [COUNT_W-1:0]         cmd_count  = '0;
    logic                       cmd_dir    = 1'b0;
    logic                       rsp_ready  = 1'b0;
    logic                       cfg_we     = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index  = '0;
    logic [CFG_DATA_W-1:0]      cfg_data   = '0;

    assign cmd_ch.valid      = cmd_valid;
    assign cmd_ch.action     = cmd_action;
    assign cmd_ch.step_count = cmd_count;
    assign cmd_ch.move_dir   = cmd_dir;
    assign rsp_ch.ready      = rsp_ready;

    stepper_trapezoid_ramp_top #(
        .COUNT_WIDTH  (COUNT_W),
        .PERIOD_WIDTH (PERIOD_W)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Bench bookkeeping
    // ------------------------------------------------------------------------
    ramp_cmd_t   pending_cmds[$];
    drive_view_t expected_views[$];
    ramp_cmd_t   next_cmd;
    drive_view_t due_view;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int          mismatch_count = 0;
    int          items_queued   = 0;
    int          results_seen   = 0;
    int          settings_used  = 1;
    int          cruise_count   = 0;
    int          halt_count     = 0;
    int          cycles;

    // ------------------------------------------------------------------------
    // Drive model: register copies and the state they act on
    // ------------------------------------------------------------------------
    logic [PERIOD_W-1:0]      cfg_slow   = PERIOD_W'(SLOW_PERIOD_RST);
    logic [PERIOD_W-1:0]      cfg_fast   = PERIOD_W'(FAST_PERIOD_RST);
    logic [PERIOD_W-1:0]      cfg_ramp   = PERIOD_W'(RAMP_STEP_RST);
    logic [CURRENT_WIDTH-1:0] cfg_run_i  = RUN_CURRENT_RST;
    logic [CURRENT_WIDTH-1:0] cfg_stop_i = STOP_CURRENT_RST;

    logic [STATUS_WIDTH-1:0]  ramp_status  = STATUS_STOPPED;
    logic [PERIOD_W-1:0]      ramp_period  = PERIOD_W'(SLOW_PERIOD_RST);
    logic [COUNT_W-1:0]       trip_total   = '0;
    logic [COUNT_W-1:0]       trip_passed  = '0;
    logic [COUNT_W-1:0]       trip_accel   = '0;
    logic [COUNT_W-1:0]       pulse_cnt    = '0;
    logic [COUNT_W-1:0]       pulse_limit  = '0;
    logic                     free_run     = 1'b0;
    logic                     dir_latch    = 1'b0;
    logic [CURRENT_WIDTH-1:0] coil_current = STOP_CURRENT_RST;
    logic                     pulse_gen_on = 1'b0;
    logic                     tick_gen_on  = 1'b0;

    // Launch the ramp from the slow period with both timers running
    function automatic void start_drive();
        ramp_period  = cfg_slow;
        coil_current = (cfg_run_i < cfg_stop_i) ? cfg_stop_i : cfg_run_i;
        ramp_status  = STATUS_ACCEL;
        pulse_gen_on = 1'b1;
        tick_gen_on  = 1'b1;
    endfunction

    // Drop to the holding current and clear the trip; the period is kept
    function automatic void stop_drive();
        pulse_gen_on = 1'b0;
        tick_gen_on  = 1'b0;
        coil_current = cfg_stop_i;
        ramp_status  = STATUS_STOPPED;
        pulse_cnt    = '0;
        trip_total   = '0;
        trip_passed  = '0;
        trip_accel   = '0;
        halt_count++;
    endfunction

    // Apply one command item to the model and return the drive view after it
    function automatic drive_view_t advance_ramp(input logic [ACTION_WIDTH-1:0] act,
                                                 input logic [COUNT_W-1:0] count,
                                                 input logic dir);
        logic [COUNT_W+1:0] brake_from;
        logic [COUNT_W+1:0] brake_margin;
        drive_view_t        view;
        case (act)
            ACT_MOVE:
            begin
                trip_total  = count - 1'b1;     // a zero count wraps to the top
                pulse_limit = trip_total;
                trip_passed = '0;
                pulse_cnt   = '0;
                dir_latch   = dir;
                free_run    = 1'b0;
                start_drive();
            end
            ACT_RUN:
            begin
                free_run = 1'b1;
                start_drive();
            end
            ACT_TICK:
            begin
                if (tick_gen_on && ramp_status == STATUS_ACCEL)
                begin
                    // Compare without wrap: the sum is one bit wider
                    if ({1'b0, ramp_period} <= {1'b0, cfg_fast} + {1'b0, cfg_ramp})
                    begin
                        trip_accel   = pulse_cnt;
                        trip_passed  = trip_passed + trip_accel;
                        ramp_period  = cfg_fast;
                        ramp_status  = STATUS_CRUISE;
                        tick_gen_on  = 1'b0;
                        // Braking point: total + 1 - 2 * (accel + 2), held at zero
                        brake_from   = {2'b00, trip_total} + 1'b1;
                        brake_margin = ({2'b00, trip_accel} + 2'd2) << 1;
                        pulse_limit  = (brake_from > brake_margin)
                                       ? COUNT_W'(brake_from - brake_margin) : '0;
                        cruise_count++;
                    end
                    else
                    begin
                        ramp_period = ramp_period - cfg_ramp;
                    end
                end
                else if (tick_gen_on && ramp_status == STATUS_BRAKE)
                begin
                    if ({1'b0, ramp_period} + {1'b0, cfg_ramp} >= {1'b0, cfg_slow})
                    begin
                        ramp_period = cfg_slow;
                        if (free_run)
                            stop_drive();
                        else
                            tick_gen_on = 1'b0;
                    end
                    else
                    begin
                        ramp_period = ramp_period + cfg_ramp;
                    end
                end
            end
            ACT_PULSE:
            begin
                if (pulse_gen_on && pulse_cnt >= pulse_limit)
                begin
                    pulse_cnt = '0;
                    // Limit events mean nothing in free run or before cruise
                    if (!free_run && ramp_status == STATUS_CRUISE)
                    begin
                        trip_passed = trip_passed + pulse_limit;
                        pulse_limit = (trip_total > trip_passed)
                                      ? trip_total - trip_passed : '0;
                        ramp_status = STATUS_BRAKE;
                        tick_gen_on = 1'b1;
                    end
                    else if (!free_run && ramp_status == STATUS_BRAKE)
                    begin
                        stop_drive();
                    end
                end
                else if (pulse_gen_on)
                begin
                    pulse_cnt = pulse_cnt + 1'b1;
                end
            end
            ACT_BRAKE:
            begin
                if (ramp_status != STATUS_STOPPED)
                begin
                    ramp_status = STATUS_BRAKE;
                    tick_gen_on = 1'b1;
                end
            end
            default:
            begin
                // spare codes leave the drive untouched
            end
        endcase
        view.period    = ramp_period;
        view.status    = ramp_status;
        view.dir       = dir_latch;
        view.current   = coil_current;
        view.pulses_on = pulse_gen_on;
        view.ticks_on  = tick_gen_on;
        return view;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: present the next pending item, idling at the phase's rate
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
        end
        else if (!cmd_valid || cmd_ch.ready)
        begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_cmd   = pending_cmds.pop_front();
                cmd_valid  <= 1'b1;
                cmd_action <= next_cmd.action;
                cmd_count  <= next_cmd.count;
                cmd_dir    <= next_cmd.dir;
            end
            else
            begin
                cmd_valid <= 1'b0;
            end
        end
    end

    // Stall the result channel at the phase's rate
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on every accepted command, check every accepted result
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t: %s: got %0d, want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
                expected_views.push_back(advance_ramp(cmd_ch.action, cmd_ch.step_count,
                                                      cmd_ch.move_dir));
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen++;
                if (expected_views.size() == 0)
                begin
                    report_mismatch("result with nothing outstanding", rsp_ch.motor_status, 0);
                end
                else
                begin
                    due_view = expected_views.pop_front();
                    if (rsp_ch.step_period !== due_view.period)
                        report_mismatch("step_period", rsp_ch.step_period, due_view.period);
                    if (rsp_ch.motor_status !== due_view.status)
                        report_mismatch("motor_status", rsp_ch.motor_status, due_view.status);
                    if (rsp_ch.dir_out !== due_view.dir)
                        report_mismatch("dir_out", rsp_ch.dir_out, due_view.dir);
                    if (rsp_ch.current_setpoint !== due_view.current)
                        report_mismatch("current_setpoint", rsp_ch.current_setpoint,
                                        due_view.current);
                    if (rsp_ch.pulses_on !== due_view.pulses_on)
                        report_mismatch("pulses_on", rsp_ch.pulses_on, due_view.pulses_on);
                    if (rsp_ch.ramp_ticks_on !== due_view.ticks_on)
                        report_mismatch("ramp_ticks_on", rsp_ch.ramp_ticks_on,
                                        due_view.ticks_on);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_cmd(input logic [ACTION_WIDTH-1:0] act,
                             input logic [COUNT_W-1:0] count, input logic dir);
        ramp_cmd_t item;
        item.action = act;
        item.count  = count;
        item.dir    = dir;
        pending_cmds.push_back(item);
        items_queued++;
    endtask

    // Mostly short trips so that limit events and full ramps come often
    function automatic logic [COUNT_W-1:0] pick_count();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 1)
            return '0;
        else if (roll < 65)
            return COUNT_W'($urandom_range(12, 1));
        else if (roll < 88)
            return COUNT_W'($urandom_range(300, 13));
        else
            return COUNT_W'($urandom_range((1 << COUNT_W) - 1, 1));
    endfunction

    // One trip: a start (now and then any code), then a mix of ticks and pulses with the odd brake,
    // restart or spare code. Unused fields carry random bits.
    task automatic queue_trip();
        int unsigned roll;
        int          body;
        roll = $urandom_range(99);
        if (roll < 70)
            queue_cmd(ACT_MOVE, pick_count(), 1'($urandom_range(1)));
        else if (roll < 92)
            queue_cmd(ACT_RUN, COUNT_W'($urandom), 1'($urandom_range(1)));
        else
            queue_cmd(ACTION_WIDTH'($urandom_range(ACT_SPARE_LAST)), COUNT_W'($urandom),
                      1'($urandom_range(1)));
        body = $urandom_range(40, 8);
        repeat (body)
        begin
            roll = $urandom_range(99);
            if (roll < 46)
                queue_cmd(ACT_TICK, COUNT_W'($urandom), 1'($urandom_range(1)));
            else if (roll < 92)
                queue_cmd(ACT_PULSE, COUNT_W'($urandom), 1'($urandom_range(1)));
            else if (roll < 95)
                queue_cmd(ACT_BRAKE, COUNT_W'($urandom), 1'($urandom_range(1)));
            else if (roll < 97)
                queue_cmd(ACTION_WIDTH'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST)),
                          COUNT_W'($urandom), 1'($urandom_range(1)));
            else
                queue_cmd(ACT_MOVE, pick_count(), 1'($urandom_range(1)));
        end
    endtask

    // Register write; the model copy is updated at once since nothing is in flight
    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_SLOW_PERIOD:  cfg_slow   = value[PERIOD_W-1:0];
            REG_FAST_PERIOD:  cfg_fast   = value[PERIOD_W-1:0];
            REG_RAMP_STEP:    cfg_ramp   = value[PERIOD_W-1:0];
            REG_RUN_CURRENT:  cfg_run_i  = value[CURRENT_WIDTH-1:0];
            REG_STOP_CURRENT: cfg_stop_i = value[CURRENT_WIDTH-1:0];
            default:          ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_ramp(input int unsigned slow, input int unsigned fast,
                            input int unsigned step, input int unsigned run_i,
                            input int unsigned stop_i);
        write_reg(REG_SLOW_PERIOD, CFG_DATA_W'(slow));
        write_reg(REG_FAST_PERIOD, CFG_DATA_W'(fast));
        write_reg(REG_RAMP_STEP, CFG_DATA_W'(step));
        write_reg(REG_RUN_CURRENT, CFG_DATA_W'(run_i));
        write_reg(REG_STOP_CURRENT, CFG_DATA_W'(stop_i));
        settings_used++;
    endtask

    // Hold until every queued item has gone through and its result is back
    task automatic drain();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || cmd_valid || expected_views.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_pressure(input int mode);
        case (mode)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 72; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 72; end
            default: begin send_idle_pct = 33; recv_stall_pct = 33; end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Run: directed phases first, then random phases across settings
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned slow;
        int unsigned fast;
        int          target;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: ignored items while stopped, spare codes, zero-count
        // wrap, restart while moving, and a free run braked to a halt
        set_pressure(0);
        @(negedge clk);
        queue_cmd(ACT_PULSE, '1, 1'b1);
        queue_cmd(ACT_TICK, '0, 1'b0);
        queue_cmd(ACT_BRAKE, '1, 1'b1);
        queue_cmd(ACT_SPARE_FIRST, '0, 1'b0);
        queue_cmd(ACT_SPARE_LAST, '1, 1'b1);
        queue_cmd(ACT_MOVE, '0, 1'b1);
        queue_cmd(ACT_PULSE, '0, 1'b0);
        queue_cmd(ACT_MOVE, '1, 1'b0);
        queue_cmd(ACT_RUN, '0, 1'b1);
        queue_cmd(ACT_TICK, '0, 1'b0);
        queue_cmd(ACT_BRAKE, '0, 1'b0);
        queue_cmd(ACT_TICK, '1, 1'b1);
        drain();

        // Short ramp, run current below stop current: a full move of three
        // steps through cruise and braking, then a free run that ends on a tick
        set_ramp(40, 10, 10, 0, 4095);
        set_pressure(3);
        @(negedge clk);
        queue_cmd(ACT_MOVE, COUNT_W'(3), 1'b1);
        queue_cmd(ACT_TICK, '0, 1'b0);
        queue_cmd(ACT_PULSE, '0, 1'b0);
        queue_cmd(ACT_TICK, '0, 1'b0);
        queue_cmd(ACT_TICK, '0, 1'b0);
        queue_cmd(ACT_PULSE, '0, 1'b0);
        queue_cmd(ACT_TICK, '0, 1'b0);
        queue_cmd(ACT_TICK, '0, 1'b0);
        queue_cmd(ACT_TICK, '0, 1'b0);
        queue_cmd(ACT_PULSE, '0, 1'b0);
        queue_cmd(ACT_PULSE, '0, 1'b0);
        queue_cmd(ACT_RUN, '0, 1'b0);
        queue_cmd(ACT_BRAKE, '0, 1'b0);
        queue_cmd(ACT_TICK, '0, 1'b0);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: set_ramp(65535, 1, 65535, 4095, 0);      // widest ramp, one tick
                1: set_ramp(1, 1, 1, 0, 4095);              // narrowest values
                2: set_ramp(1, 65535, 1, $urandom_range(4095), $urandom_range(4095));
                default:
                begin
                    // Moderate ramps of a handful of ticks
                    slow = $urandom_range(400, 20);
                    fast = $urandom_range(slow, 1);
                    set_ramp(slow, fast, (slow - fast) / $urandom_range(6, 1) + 1,
                             $urandom_range(4095), $urandom_range(4095));
                end
            endcase
            // A write past the last register must change nothing
            if (phase == 3)
                write_reg(REG_STOP_CURRENT + 1'b1, CFG_DATA_W'($urandom));
            set_pressure(phase % 4);
            @(negedge clk);
            target = items_queued + RANDOM_ITEMS;
            while (items_queued < target)
                queue_trip();
            drain();
        end

        $display("%0d command items, %0d results checked over %0d register settings",
                 items_queued, results_seen, settings_used);
        $display("%0d ramps reached cruise, %0d drives stopped, %0d mismatches",
                 cruise_count, halt_count, mismatch_count);
        if (mismatch_count == 0)
            $display("stepper_trapezoid_ramp_top: match");
        else
            $display("stepper_trapezoid_ramp_top: mismatch");
        $finish;
    end

    // Give up if the run stalls
    initial
    begin
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge clk);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycles, expected_views.size());
        $display("stepper_trapezoid_ramp_top: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/stramp_pkg.sv
hw/rtl/stramp_if.sv
hw/rtl/stramp_core.sv
hw/rtl/stepper_trapezoid_ramp_top.sv
dv/stepper_trapezoid_ramp_top_test.sv
